### hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and bit helpers for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGE_W = 12;
  localparam int CNT_W  = 13;
  localparam int RES_W  = 12;
  localparam int FREE_W = 13;

  typedef enum logic [2:0] {
    ACT_ALLOC_ONE   = 3'd0,
    ACT_ALLOC_BELOW = 3'd1,
    ACT_ALLOC_RUN   = 3'd2,
    ACT_FREE        = 3'd3,
    ACT_PIN         = 3'd4,
    ACT_MARK_AVAIL  = 3'd5,
    ACT_RESERVE     = 3'd6,
    ACT_NOP         = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SCAN, S_FILL_RD, S_FILL_WR,
    S_CHK_RD, S_CHK_WR, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_NOSPACE, CMD_INVALID,
    CMD_SCAN_START, CMD_SCAN_STEP, CMD_RANGE_START,
    CMD_FILL_RD, CMD_FILL_WR, CMD_CHK_RD, CMD_CHK_WR, CMD_EMIT
  } cmd_t;

  typedef struct packed {
    cmd_t op;
  } dp_cmd_t;

  typedef struct packed {
    action_t act;
    logic    clr_last;
    logic    free_zero;
    logic    run_bad;
    logic    page_oob;
    logic    range_empty;
    logic    scan_hit;
    logic    scan_miss;
    logic    fill_last;
    logic    out_free;
  } dp_stat_t;

  // index of lowest set bit (0 when none)
  function automatic logic [4:0] lsb_index(input logic [31:0] x);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (x[i]) r = 5'(i);
    end
    return r;
  endfunction

  // index of highest set bit (0 when none)
  function automatic logic [4:0] msb_index(input logic [31:0] x);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) r = 5'(i);
    end
    return r;
  endfunction

  function automatic logic [5:0] popcount32(input logic [31:0] x);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 0; i < 32; i++) begin
      r = r + 6'(x[i]);
    end
    return r;
  endfunction

endpackage

### hw/rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: clear pass, request decode, scan, fill, check and result hand-off.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  bpa_pkg::dp_stat_t  stat,
  output bpa_pkg::dp_cmd_t   cmd
);
  import bpa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = CMD_NONE;
    s_tready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = CMD_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op     = CMD_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.act)
          ACT_ALLOC_ONE, ACT_ALLOC_BELOW: begin
            if (stat.free_zero) begin
              cmd.op     = CMD_NOSPACE;
              state_next = S_DONE;
            end else begin
              cmd.op     = CMD_SCAN_START;
              state_next = S_SCAN;
            end
          end
          ACT_ALLOC_RUN: begin
            if (stat.run_bad) begin
              cmd.op     = CMD_NOSPACE;
              state_next = S_DONE;
            end else begin
              cmd.op     = CMD_SCAN_START;
              state_next = S_SCAN;
            end
          end
          ACT_FREE, ACT_PIN: begin
            if (stat.page_oob) begin
              cmd.op     = CMD_INVALID;
              state_next = S_DONE;
            end else begin
              state_next = S_CHK_RD;
            end
          end
          ACT_MARK_AVAIL, ACT_RESERVE: begin
            if (stat.range_empty) begin
              state_next = S_DONE;
            end else begin
              cmd.op     = CMD_RANGE_START;
              state_next = S_FILL_RD;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd.op = CMD_SCAN_STEP;
        if (stat.scan_hit) state_next = S_FILL_RD;
        else if (stat.scan_miss) state_next = S_DONE;
      end
      S_FILL_RD: begin
        cmd.op     = CMD_FILL_RD;
        state_next = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd.op     = CMD_FILL_WR;
        state_next = stat.fill_last ? S_DONE : S_FILL_RD;
      end
      S_CHK_RD: begin
        cmd.op     = CMD_CHK_RD;
        state_next = S_CHK_WR;
      end
      S_CHK_WR: begin
        cmd.op     = CMD_CHK_WR;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hw/rtl/bpa_datapath.sv
// ----------------------------------------------------------------------------
// bpa_datapath
// Bitmap memory, request latch, word scanner, range fill and result register.
// ----------------------------------------------------------------------------
module bpa_datapath #(
  parameter int NUM_PAGES = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [39:0]              s_tdata,
  input  logic [2:0]               s_tuser,
  input  bpa_pkg::dp_cmd_t         cmd,
  output bpa_pkg::dp_stat_t        stat,
  input  logic                     m_tready,
  output logic                     m_tvalid,
  output logic [31:0]              m_tdata,
  output logic [1:0]               m_tuser
);
  import bpa_pkg::*;

  localparam int WORDS = NUM_PAGES / 32;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW    = $clog2(NUM_PAGES + 1);
  localparam int XW    = (PW > CNT_W) ? PW : CNT_W;
  localparam int EW    = XW + 1;
  localparam logic [31:0] ONES = 32'hffff_ffff;

  // word layout: owned in the upper half, busy in the lower half
  logic [63:0] mem [WORDS];
  logic [63:0] rd_data;
  logic        rd_en, wr_en;
  logic [WAW-1:0] rd_addr, wr_addr;
  logic [63:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // request
  action_t           q_act;
  logic [PAGE_W-1:0] q_page;
  logic [CNT_W-1:0]  q_count, q_limit;

  // allocator state
  logic [PW-1:0]  free_total, free_total_next;
  logic [WAW-1:0] cursor;
  logic [WAW-1:0] clr_cnt;

  // scan
  logic [WAW:0]   iss, nwords;
  logic           dv;
  logic [WAW-1:0] dw;
  logic [PW-1:0]  run_len;

  // range fill
  logic [PW-1:0]  r_first, r_last;
  logic [WAW-1:0] r_word;
  logic           r_busy, r_owned;

  // result
  logic [RES_W-1:0] res_page;
  status_t          res_st;

  logic [EW-1:0] page_x, count_x, limit_x, n_x, top_x, tw_x, end_x, last_x;
  logic [WAW:0]  addr_sum;
  logic [WAW-1:0] scan_addr;
  logic          issue;

  assign page_x  = EW'(q_page);
  assign count_x = EW'(q_count);
  assign limit_x = EW'(q_limit);
  assign n_x     = EW'(NUM_PAGES);
  assign top_x   = (limit_x < n_x) ? limit_x : n_x;
  assign tw_x    = (top_x + EW'(31)) >> 5;
  assign end_x   = (count_x > n_x - page_x) ? n_x : page_x + count_x;
  assign last_x  = end_x - EW'(1);

  assign issue    = (iss != nwords);
  assign addr_sum = (q_act == ACT_ALLOC_ONE) ? ({1'b0, cursor} + iss) : iss;
  assign scan_addr = (addr_sum >= (WAW+1)'(WORDS)) ? WAW'(addr_sum - (WAW+1)'(WORDS))
                                                   : addr_sum[WAW-1:0];

  // ---- word evaluation on the returned scan word
  logic [31:0]   w_busy, w_owned, cand, lim_mask, hitv;
  logic [EW-1:0] wbase_x, pg_hit_x;
  logic [EW-1:0] tot [32];
  logic [4:0]    one_b, run_b, hb;
  logic          hit;
  logic [PW-1:0] run_next;

  assign w_busy  = rd_data[31:0];
  assign w_owned = rd_data[63:32];
  assign wbase_x = EW'(dw) << 5;

  always_comb begin
    logic [31:0] lowm;
    lim_mask = ONES;
    if (q_act == ACT_ALLOC_BELOW && (wbase_x + EW'(32) > top_x))
      lim_mask = ~(ONES << top_x[4:0]);
    cand  = ~w_busy & lim_mask;
    one_b = lsb_index(cand);
    for (int b = 0; b < 32; b++) begin
      lowm   = ONES >> (5'd31 - 5'(b));
      if ((w_busy & lowm) != 32'd0)
        tot[b] = EW'(5'(b) - msb_index(w_busy & lowm));
      else
        tot[b] = EW'(run_len) + EW'(b + 1);
      hitv[b] = ~w_busy[b] && (tot[b] >= count_x);
    end
    run_b = lsb_index(hitv);
    if (w_busy == 32'd0) run_next = PW'(EW'(run_len) + EW'(32));
    else                 run_next = PW'(5'd31 - msb_index(w_busy));
    if (q_act == ACT_ALLOC_RUN) begin
      hit = dv && (hitv != 32'd0);
      hb  = run_b;
    end else begin
      hit = dv && (cand != 32'd0);
      hb  = one_b;
    end
    pg_hit_x = wbase_x + EW'(hb);
  end

  // ---- range fill word
  logic [4:0]  f_lo, f_hi;
  logic [31:0] f_mask, c_bit;
  logic [5:0]  f_delta;
  logic        c_owned;

  always_comb begin
    f_lo    = (r_word == WAW'(r_first >> 5)) ? r_first[4:0] : 5'd0;
    f_hi    = (r_word == WAW'(r_last >> 5))  ? r_last[4:0]  : 5'd31;
    f_mask  = (ONES << f_lo) & (ONES >> (5'd31 - f_hi));
    f_delta = popcount32(r_busy ? (f_mask & ~w_busy) : (f_mask & w_busy));
    c_bit   = 32'd1 << q_page[4:0];
    c_owned = (w_owned & c_bit) != 32'd0;
  end

  // ---- memory ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_addr;
    wr_en   = 1'b0;
    wr_addr = r_word;
    wr_data = rd_data;
    free_total_next = free_total;
    case (cmd.op)
      CMD_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = {32'd0, ONES};
      end
      CMD_SCAN_STEP: rd_en = issue;
      CMD_FILL_RD: begin
        rd_en   = 1'b1;
        rd_addr = r_word;
      end
      CMD_FILL_WR: begin
        wr_en   = 1'b1;
        wr_data = {r_owned ? (w_owned | f_mask) : w_owned,
                   r_busy  ? (w_busy | f_mask)  : (w_busy & ~f_mask)};
        free_total_next = r_busy ? free_total - PW'(f_delta) : free_total + PW'(f_delta);
      end
      CMD_CHK_RD: begin
        rd_en   = 1'b1;
        rd_addr = WAW'(q_page >> 5);
      end
      CMD_CHK_WR: begin
        wr_en   = c_owned;
        wr_addr = WAW'(q_page >> 5);
        wr_data = {w_owned & ~c_bit,
                   (q_act == ACT_FREE) ? (w_busy & ~c_bit) : w_busy};
        if (c_owned && q_act == ACT_FREE && (w_busy & c_bit) != 32'd0)
          free_total_next = free_total + PW'(1);
      end
      default: ;
    endcase
  end

  // ---- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      free_total <= '0;
      cursor     <= '0;
      m_tvalid   <= 1'b0;
      dv         <= 1'b0;
    end else begin
      free_total <= free_total_next;
      if (cmd.op == CMD_EMIT) m_tvalid <= 1'b1;
      else if (m_tready)      m_tvalid <= 1'b0;
      case (cmd.op)
        CMD_CLEAR: clr_cnt <= clr_cnt + WAW'(1);
        CMD_LOAD: begin
          q_act    <= action_t'(s_tuser);
          q_page   <= s_tdata[11:0];
          q_count  <= s_tdata[24:12];
          q_limit  <= s_tdata[37:25];
          res_page <= '0;
          res_st   <= ST_OK;
        end
        CMD_NOSPACE: res_st <= ST_NOSPACE;
        CMD_INVALID: res_st <= ST_INVALID;
        CMD_SCAN_START: begin
          iss     <= '0;
          dv      <= 1'b0;
          run_len <= '0;
          if (q_act == ACT_ALLOC_BELOW) nwords <= tw_x[WAW:0];
          else                          nwords <= (WAW+1)'(WORDS);
        end
        CMD_SCAN_STEP: begin
          dv <= issue;
          dw <= scan_addr;
          if (issue) iss <= iss + (WAW+1)'(1);
          if (dv) run_len <= run_next;
          if (hit) begin
            r_last  <= PW'(pg_hit_x);
            r_busy  <= 1'b1;
            r_owned <= 1'b1;
            if (q_act == ACT_ALLOC_RUN) begin
              r_first  <= PW'(pg_hit_x + EW'(1) - count_x);
              r_word   <= WAW'((pg_hit_x + EW'(1) - count_x) >> 5);
              res_page <= RES_W'(pg_hit_x + EW'(1) - count_x);
            end else begin
              r_first  <= PW'(pg_hit_x);
              r_word   <= dw;
              res_page <= RES_W'(pg_hit_x);
            end
            if (q_act == ACT_ALLOC_ONE) cursor <= dw;
          end else if (!issue) begin
            res_st <= ST_NOSPACE;
          end
        end
        CMD_RANGE_START: begin
          r_first <= PW'(page_x);
          r_last  <= PW'(last_x);
          r_word  <= WAW'(page_x >> 5);
          r_busy  <= (q_act == ACT_RESERVE);
          r_owned <= 1'b0;
        end
        CMD_FILL_WR: r_word <= r_word + WAW'(1);
        CMD_CHK_WR: if (!c_owned) res_st <= ST_INVALID;
        CMD_EMIT: begin
          m_tdata  <= {7'd0, FREE_W'(free_total), res_page};
          m_tuser  <= res_st;
        end
        default: ;
      endcase
    end
  end

  // ---- status to the sequencer
  always_comb begin
    stat.act         = q_act;
    stat.clr_last    = (clr_cnt == WAW'(WORDS - 1));
    stat.free_zero   = (free_total == '0);
    stat.run_bad     = (q_count == '0) || (EW'(free_total) < count_x);
    stat.page_oob    = (page_x >= n_x);
    stat.range_empty = (page_x >= n_x) || (q_count == '0);
    stat.scan_hit    = hit;
    stat.scan_miss   = !hit && !issue;
    stat.fill_last   = (r_word == WAW'(r_last >> 5));
    stat.out_free    = !m_tvalid || m_tready;
  end

endmodule

### hw/rtl/bitmap_page_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core
// Physical page frame allocator over a busy bitmap and an owned bitmap.
// ----------------------------------------------------------------------------
// One request word in, one result word out. After reset a clearing pass
// over all NUM_PAGES/32 bitmap words (128 at the default) marks every page
// busy; no request is taken until it ends. Requests run one at a time
// through a bitmap memory with one read port and one write port, holding
// 32 pages per entry. Alloc-one, alloc-below and alloc-run read one bitmap
// word per cycle from the scan start, then take a read/write pair per word
// touched (the one word for a single page, each spanned word for a run).
// Mark-available and reserve take a read/write pair per spanned word; free
// and pin read the page's word and write it back only if the page is owned.
// A finished result sits in the output register so the next request can be
// accepted while it waits.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core #(
  parameter int NUM_PAGES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // page[11:0], count[24:12], limit_page[37:25]
  input  logic [2:0]  s_tuser,   // action[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_page[11:0], free_pages[24:12]
  output logic [1:0]  m_tuser    // status[1:0]
);
  import bpa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // bitmaps, counters and output register
  bpa_datapath #(
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
